### hdl/sdtq_pkg.sv
package sdtq_pkg;

	// Defaults for the top-level parameters
	localparam int DEPTH_DEF     = 16;
	localparam int TIME_BITS_DEF = 32;

	// Fixed field widths
	localparam int HANDLE_W = 8;
	localparam int STATUS_W = 3;
	localparam int OP_W     = 2;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_ADJUST = 2'd1,
		OP_DELETE = 2'd2,
		OP_TICK   = 2'd3
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_EXPIRED   = 3'd3,
		ST_DONE      = 3'd4
	} status_t;

	// Controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_ADJ_PLACE,
		S_TICK
	} state_t;

	// Command broadcast to every cell
	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_INSERT,
		CMD_REMOVE
	} cmd_t;

	typedef struct packed {
		cmd_t                cmd;
		logic                match_en;
		logic [HANDLE_W-1:0] key_handle;
	} cell_ctrl_t;

endpackage

### hdl/sdtq_cell.sv
module sdtq_cell #(
	parameter int TIME_BITS = sdtq_pkg::TIME_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sdtq_pkg::cell_ctrl_t            ctrl,
	input  logic [TIME_BITS-1:0]            key_deadline,
	input  logic                            left_gt,
	input  logic                            left_valid,
	input  logic [sdtq_pkg::HANDLE_W-1:0]   left_handle,
	input  logic [TIME_BITS-1:0]            left_deadline,
	input  logic                            right_valid,
	input  logic [sdtq_pkg::HANDLE_W-1:0]   right_handle,
	input  logic [TIME_BITS-1:0]            right_deadline,
	input  logic                            kill_in,
	output logic                            gt,
	output logic                            kill_out,
	output logic                            valid,
	output logic [sdtq_pkg::HANDLE_W-1:0]   handle,
	output logic [TIME_BITS-1:0]            deadline
);
	import sdtq_pkg::*;

	logic                valid_q, valid_d;
	logic [HANDLE_W-1:0] handle_q, handle_d;
	logic [TIME_BITS-1:0] deadline_q, deadline_d;

	// New item goes in front of this cell: empty, or later deadline
	assign gt = !valid_q || (deadline_q > key_deadline);

	// Removal point ripples right from the first matching cell
	assign kill_out = kill_in || (ctrl.match_en && valid_q && (handle_q == ctrl.key_handle));

	assign valid    = valid_q;
	assign handle   = handle_q;
	assign deadline = deadline_q;

	// Insert shifts right from the insert point, remove shifts left
	always_comb begin
		valid_d    = valid_q;
		handle_d   = handle_q;
		deadline_d = deadline_q;
		case (ctrl.cmd)
			CMD_INSERT: begin
				if (gt) begin
					if (left_gt) begin
						valid_d    = left_valid;
						handle_d   = left_handle;
						deadline_d = left_deadline;
					end else begin
						valid_d    = 1'b1;
						handle_d   = ctrl.key_handle;
						deadline_d = key_deadline;
					end
				end
			end
			CMD_REMOVE: begin
				if (kill_out) begin
					valid_d    = right_valid;
					handle_d   = right_handle;
					deadline_d = right_deadline;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	// Payload, no reset
	always_ff @(posedge clk) begin
		handle_q   <= handle_d;
		deadline_q <= deadline_d;
	end

endmodule

### hdl/sorted_deadline_timer_queue.sv
// Insert and delete give their result from the execute state after the item is accepted;
// adjust takes a remove pass, then a place pass; tick pops one expired timer per cycle
// from the head cell while the output is free, then gives the done item.
// Items are handled one at a time: the next is accepted once the controller is back in
// idle, which it enters as the last result is registered; output stalls hold it off.
// Reset clears all cell valid bits and the controller; the table starts empty.
module sorted_deadline_timer_queue #(
	parameter int DEPTH     = sdtq_pkg::DEPTH_DEF,
	parameter int TIME_BITS = sdtq_pkg::TIME_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [sdtq_pkg::OP_W-1:0]     operation,
	input  logic [sdtq_pkg::HANDLE_W-1:0] handle,
	input  logic [31:0]                   deadline,
	input  logic [31:0]                   now_time,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [sdtq_pkg::STATUS_W-1:0] status,
	output logic [sdtq_pkg::HANDLE_W-1:0] expired_handle,
	output logic                          last
);
	import sdtq_pkg::*;

	state_t               state_q, state_d;
	op_t                  op_q;
	logic [HANDLE_W-1:0]  handle_q;
	logic [TIME_BITS-1:0] deadline_q;
	logic [TIME_BITS-1:0] now_q;

	logic                 out_valid_q;
	status_t              status_q;
	logic [HANDLE_W-1:0]  exp_handle_q;
	logic                 last_q;

	// Chain wiring
	logic                 cv    [DEPTH];
	logic [HANDLE_W-1:0]  ch    [DEPTH];
	logic [TIME_BITS-1:0] cd    [DEPTH];
	logic                 cgt   [DEPTH];
	logic                 ckill [DEPTH];

	cell_ctrl_t           ctrl;
	cmd_t                 cmd;
	logic                 match_en;
	logic                 kill_head;
	logic                 out_free;
	logic                 found;
	logic                 full;
	logic                 head_expired;
	logic                 emit;
	status_t              emit_status;
	logic [HANDLE_W-1:0]  emit_handle;
	logic                 emit_last;

	assign out_free     = !out_valid_q || out_ready;
	assign found        = ckill[DEPTH-1];
	assign full         = cv[DEPTH-1];
	assign head_expired = cv[0] && (cd[0] <= now_q);
	assign in_ready     = (state_q == S_IDLE);

	assign ctrl.cmd        = cmd;
	assign ctrl.match_en   = match_en;
	assign ctrl.key_handle = handle_q;

	// Row of cells, neighbors wired left and right
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                 l_gt, l_v, r_v, k_in;
		logic [HANDLE_W-1:0]  l_h, r_h;
		logic [TIME_BITS-1:0] l_d, r_d;

		if (i == 0) begin : g_head
			assign l_gt = 1'b0;
			assign l_v  = 1'b0;
			assign l_h  = '0;
			assign l_d  = '0;
			assign k_in = kill_head;
		end else begin : g_mid
			assign l_gt = cgt[i-1];
			assign l_v  = cv[i-1];
			assign l_h  = ch[i-1];
			assign l_d  = cd[i-1];
			assign k_in = ckill[i-1];
		end

		if (i == DEPTH-1) begin : g_tail
			assign r_v = 1'b0;
			assign r_h = '0;
			assign r_d = '0;
		end else begin : g_body
			assign r_v = cv[i+1];
			assign r_h = ch[i+1];
			assign r_d = cd[i+1];
		end

		sdtq_cell #(
			.TIME_BITS (TIME_BITS)
		) u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.ctrl           (ctrl),
			.key_deadline   (deadline_q),
			.left_gt        (l_gt),
			.left_valid     (l_v),
			.left_handle    (l_h),
			.left_deadline  (l_d),
			.right_valid    (r_v),
			.right_handle   (r_h),
			.right_deadline (r_d),
			.kill_in        (k_in),
			.gt             (cgt[i]),
			.kill_out       (ckill[i]),
			.valid          (cv[i]),
			.handle         (ch[i]),
			.deadline       (cd[i])
		);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (op_q == OP_TICK) begin
					state_d = S_TICK;
				end else if (out_free) begin
					if (op_q == OP_ADJUST && found) begin
						state_d = S_ADJ_PLACE;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_ADJ_PLACE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_TICK: begin
				if (out_free && !head_expired) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Cell commands and result generation
	always_comb begin
		cmd         = CMD_HOLD;
		match_en    = 1'b0;
		kill_head   = 1'b0;
		emit        = 1'b0;
		emit_status = ST_OK;
		emit_handle = '0;
		emit_last   = 1'b1;
		case (state_q)
			S_EXEC: begin
				if (out_free) begin
					case (op_q)
						OP_INSERT: begin
							emit = 1'b1;
							if (full) begin
								emit_status = ST_FULL;
							end else begin
								cmd = CMD_INSERT;
							end
						end
						OP_ADJUST, OP_DELETE: begin
							match_en = 1'b1;
							cmd      = CMD_REMOVE;
							if (!found) begin
								emit        = 1'b1;
								emit_status = ST_NOT_FOUND;
							end else if (op_q == OP_DELETE) begin
								emit = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			S_ADJ_PLACE: begin
				if (out_free) begin
					cmd  = CMD_INSERT;
					emit = 1'b1;
				end
			end
			S_TICK: begin
				if (out_free) begin
					emit = 1'b1;
					if (head_expired) begin
						cmd         = CMD_REMOVE;
						kill_head   = 1'b1;
						emit_status = ST_EXPIRED;
						emit_handle = ch[0];
						emit_last   = 1'b0;
					end else begin
						emit_status = ST_DONE;
					end
				end
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Captured item and output payload
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q       <= op_t'(operation);
			handle_q   <= handle;
			deadline_q <= TIME_BITS'(deadline);
			now_q      <= TIME_BITS'(now_time);
		end
		if (emit) begin
			status_q     <= emit_status;
			exp_handle_q <= emit_handle;
			last_q       <= emit_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign expired_handle = exp_handle_q;
	assign last           = last_q;

endmodule
